FILE: rtl/btrl_pkg.sv
package btrl_pkg;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned LEN_W    = 6;
  localparam int unsigned HOP_W    = 32;
  localparam int unsigned PORT_W   = 8;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned STATUS_W = 2;

  localparam logic [LEN_W-1:0]   MAX_LEN   = LEN_W'(ADDR_W);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_ZERO_LEN = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

endpackage

FILE: rtl/btrl_node_mem.sv
module btrl_node_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 73
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/binary_trie_route_lookup.sv
// Channel | Handshake               | Payload
// in      | in_valid_i / in_ready_o | kind_i address_i prefix_len_i gateway_i port_i
// out     | out_valid_o/out_ready_i | found_o hop_out_o port_out_o status_o route_count_o
//
// One trie level per cycle: the node read for the next level is issued from the
// child link of the current node. Lookup: accept, walk, result. Insert: accept,
// walk, check, allocate new nodes one by one, result; zero length skips to result.
// Reset leaves an empty trie; the root lives in flops, other nodes are written
// when allocated, so no clearing pass. in_ready_o is high only while idle; a
// stalled result holds in the output register while the next item is taken.
module binary_trie_route_lookup #(
  parameter int unsigned NODE_COUNT = 4096,
  parameter int unsigned PORT_BITS  = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          kind_i,
  input  logic [btrl_pkg::ADDR_W-1:0]   address_i,
  input  logic [btrl_pkg::LEN_W-1:0]    prefix_len_i,
  input  logic [btrl_pkg::HOP_W-1:0]    gateway_i,
  input  logic [btrl_pkg::PORT_W-1:0]   port_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          found_o,
  output logic [btrl_pkg::HOP_W-1:0]    hop_out_o,
  output logic [btrl_pkg::PORT_W-1:0]   port_out_o,
  output logic [btrl_pkg::STATUS_W-1:0] status_o,
  output logic [btrl_pkg::COUNT_W-1:0]  route_count_o
);

  localparam int unsigned IW = $clog2(NODE_COUNT);
  localparam int unsigned FW = $clog2(NODE_COUNT + 1);

  typedef struct packed {
    logic [IW-1:0]                left;
    logic [IW-1:0]                right;
    logic                         valid;
    logic [btrl_pkg::HOP_W-1:0]   hop;
    logic [PORT_BITS-1:0]         port;
  } node_t;

  localparam int unsigned EW = $bits(node_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_CHECK,
    S_ALLOC,
    S_DONE
  } state_e;

  state_e                         state_q;
  logic                           kind_q;
  logic [btrl_pkg::ADDR_W-1:0]    addr_q;
  logic [btrl_pkg::LEN_W-1:0]     len_q;
  logic [btrl_pkg::HOP_W-1:0]     hop_q;
  logic [PORT_BITS-1:0]           port_q;
  logic [btrl_pkg::LEN_W-1:0]     level_q;
  logic [IW-1:0]                  cur_q;
  logic [FW-1:0]                  free_q;
  logic [btrl_pkg::COUNT_W-1:0]   count_q;
  node_t                          root_q;
  logic                           found_q;
  logic [btrl_pkg::HOP_W-1:0]     res_hop_q;
  logic [PORT_BITS-1:0]           res_port_q;
  btrl_pkg::status_e              status_q;

  logic                           out_valid_q;
  logic                           out_found_q;
  logic [btrl_pkg::HOP_W-1:0]     out_hop_q;
  logic [btrl_pkg::PORT_W-1:0]    out_port_q;
  logic [btrl_pkg::STATUS_W-1:0]  out_status_q;
  logic [btrl_pkg::COUNT_W-1:0]   out_count_q;

  logic [EW-1:0]                  rd_data;
  node_t                          rd_node;
  node_t                          cur_node;
  logic                           cur_bit;
  logic [IW-1:0]                  nxt;
  logic                           advance;
  logic [IW-1:0]                  rd_addr;
  logic [btrl_pkg::LEN_W-1:0]     needed;
  logic                           pool_full;
  node_t                          upd_node;
  logic [IW-1:0]                  fresh;
  logic [IW-1:0]                  fresh_link;
  logic                           last;
  logic [4:0]                     lvl_next;
  logic                           nxt_bit;
  node_t                          fresh_node;
  logic                           mem_we;
  logic [IW-1:0]                  mem_waddr;
  node_t                          mem_wdata;
  logic [PORT_BITS-1:0]           port_keep;
  logic [btrl_pkg::LEN_W-1:0]     len_in;
  logic [btrl_pkg::COUNT_W-1:0]   count_inc;
  logic                           out_load;

  assign rd_node  = node_t'(rd_data);
  assign cur_node = (cur_q == '0) ? root_q : rd_node;
  assign cur_bit  = addr_q[~level_q[4:0]];
  assign nxt      = cur_bit ? cur_node.right : cur_node.left;

  always_comb begin
    advance = 1'b0;
    if (state_q == S_WALK) begin
      if (kind_q == btrl_pkg::KIND_LOOKUP) begin
        advance = (level_q != btrl_pkg::MAX_LEN) && (nxt != '0);
      end else begin
        advance = (level_q != len_q) && (nxt != '0);
      end
    end
  end

  assign rd_addr = advance ? nxt : cur_q;

  assign needed    = len_q - level_q;
  assign pool_full = 32'(needed) > (32'(NODE_COUNT) - 32'(free_q));

  always_comb begin
    upd_node = cur_node;
    if (needed == '0) begin
      upd_node.valid = 1'b1;
      upd_node.hop   = hop_q;
      upd_node.port  = port_q;
    end else if (cur_bit) begin
      upd_node.right = free_q[IW-1:0];
    end else begin
      upd_node.left = free_q[IW-1:0];
    end
  end

  assign fresh      = free_q[IW-1:0];
  assign fresh_link = fresh + IW'(1);
  assign last       = (level_q + btrl_pkg::LEN_W'(1)) == len_q;
  assign lvl_next   = level_q[4:0] + 5'd1;
  assign nxt_bit    = addr_q[~lvl_next];

  always_comb begin
    fresh_node.left  = (!last && !nxt_bit) ? fresh_link : '0;
    fresh_node.right = (!last && nxt_bit) ? fresh_link : '0;
    fresh_node.valid = last;
    fresh_node.hop   = last ? hop_q : '0;
    fresh_node.port  = last ? port_q : '0;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_q;
    mem_wdata = upd_node;
    unique case (state_q)
      S_CHECK: begin
        mem_we = !pool_full && (cur_q != '0);
      end
      S_ALLOC: begin
        mem_we    = 1'b1;
        mem_waddr = fresh;
        mem_wdata = fresh_node;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  btrl_node_mem #(
    .DEPTH (NODE_COUNT),
    .WIDTH (EW)
  ) u_node_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign port_keep = PORT_BITS'(16'(port_i));
  assign len_in    = (prefix_len_i > btrl_pkg::MAX_LEN) ? btrl_pkg::MAX_LEN : prefix_len_i;
  assign count_inc = (count_q == btrl_pkg::COUNT_MAX) ? count_q
                                                      : count_q + btrl_pkg::COUNT_W'(1);
  assign out_load  = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_q      <= FW'(1);
      count_q     <= '0;
      root_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            kind_q     <= kind_i;
            addr_q     <= address_i;
            len_q      <= len_in;
            hop_q      <= gateway_i;
            port_q     <= port_keep;
            level_q    <= '0;
            cur_q      <= '0;
            found_q    <= 1'b0;
            res_hop_q  <= '0;
            res_port_q <= '0;
            if (kind_i == btrl_pkg::KIND_INSERT && prefix_len_i == '0) begin
              status_q <= btrl_pkg::ST_ZERO_LEN;
              state_q  <= S_DONE;
            end else begin
              status_q <= btrl_pkg::ST_DONE;
              state_q  <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (kind_q == btrl_pkg::KIND_LOOKUP && cur_node.valid) begin
            found_q    <= 1'b1;
            res_hop_q  <= cur_node.hop;
            res_port_q <= cur_node.port;
          end
          if (advance) begin
            cur_q   <= nxt;
            level_q <= level_q + btrl_pkg::LEN_W'(1);
          end else if (kind_q == btrl_pkg::KIND_LOOKUP) begin
            state_q <= S_DONE;
          end else begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (pool_full) begin
            status_q <= btrl_pkg::ST_FULL;
            state_q  <= S_DONE;
          end else begin
            if (cur_q == '0) begin
              root_q <= upd_node;
            end
            if (needed == '0) begin
              count_q <= count_inc;
              state_q <= S_DONE;
            end else begin
              state_q <= S_ALLOC;
            end
          end
        end
        S_ALLOC: begin
          free_q  <= free_q + FW'(1);
          level_q <= level_q + btrl_pkg::LEN_W'(1);
          if (last) begin
            count_q <= count_inc;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_found_q  <= found_q;
      out_hop_q    <= res_hop_q;
      out_port_q   <= btrl_pkg::PORT_W'(16'(res_port_q));
      out_status_q <= status_q;
      out_count_q  <= count_q;
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign found_o       = out_found_q;
  assign hop_out_o     = out_hop_q;
  assign port_out_o    = out_port_q;
  assign status_o      = out_status_q;
  assign route_count_o = out_count_q;

endmodule

FILE: test/route_lookup_checker.sv
`timescale 1ns / 100ps

module route_lookup_checker #(
  parameter int unsigned NODE_COUNT = 4096,
  parameter int unsigned PORT_BITS  = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic                          kind_i,
  input  logic [btrl_pkg::ADDR_W-1:0]   address_i,
  input  logic [btrl_pkg::LEN_W-1:0]    prefix_len_i,
  input  logic [btrl_pkg::HOP_W-1:0]    gateway_i,
  input  logic [btrl_pkg::PORT_W-1:0]   port_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic                          found_i,
  input  logic [btrl_pkg::HOP_W-1:0]    hop_out_i,
  input  logic [btrl_pkg::PORT_W-1:0]   port_out_i,
  input  logic [btrl_pkg::STATUS_W-1:0] status_i,
  input  logic [btrl_pkg::COUNT_W-1:0]  route_count_i,
  output int unsigned                   fails_o,
  output int unsigned                   pending_o,
  output int unsigned                   results_o,
  output int unsigned                   hits_o,
  output int unsigned                   full_rejects_o,
  output int unsigned                   zero_len_o
);
  import btrl_pkg::*;

  localparam int unsigned IDX_W = $clog2(NODE_COUNT);

  typedef struct packed {
    logic                found;
    logic [HOP_W-1:0]    hop;
    logic [PORT_W-1:0]   port;
    status_e             status;
    logic [COUNT_W-1:0]  count;
  } route_result_t;

  logic [IDX_W-1:0]   link_zero [NODE_COUNT];
  logic [IDX_W-1:0]   link_one  [NODE_COUNT];
  logic               node_live [NODE_COUNT];
  logic [HOP_W-1:0]   node_hop  [NODE_COUNT];
  logic [PORT_W-1:0]  node_port [NODE_COUNT];
  int unsigned        free_node;
  logic [COUNT_W-1:0] accepted_routes;

  route_result_t expected_q[$];
  route_result_t want;
  int unsigned   fails, results, hits, full_rejects, zero_len;

  initial begin
    fails = 0;
    results = 0;
    hits = 0;
    full_rejects = 0;
    zero_len = 0;
  end

  function automatic void clear_node(logic [IDX_W-1:0] idx);
    link_zero[idx] = '0;
    link_one[idx]  = '0;
    node_live[idx] = 1'b0;
    node_hop[idx]  = '0;
    node_port[idx] = '0;
  endfunction

  function automatic route_result_t insert_route(logic [ADDR_W-1:0] addr,
                                                 logic [LEN_W-1:0] len,
                                                 logic [HOP_W-1:0] hop,
                                                 logic [PORT_W-1:0] port);
    route_result_t    res;
    int unsigned      depth, level;
    logic [IDX_W-1:0] node, nxt;
    res = '0;
    res.status = ST_DONE;
    depth = 32'(len);
    if (depth == 0) begin
      res.status = ST_ZERO_LEN;
      res.count = accepted_routes;
      return res;
    end
    if (depth > ADDR_W) depth = ADDR_W;
    node = '0;
    level = 0;
    while (level < depth) begin
      nxt = addr[5'(ADDR_W-1-level)] ? link_one[node] : link_zero[node];
      if (nxt == '0) break;
      node = nxt;
      level++;
    end
    if (depth - level > NODE_COUNT - free_node) begin
      res.status = ST_FULL;
      res.count = accepted_routes;
      return res;
    end
    for (int unsigned i = level; i < depth; i++) begin
      nxt = IDX_W'(free_node);
      free_node++;
      clear_node(nxt);
      if (addr[5'(ADDR_W-1-i)]) link_one[node] = nxt;
      else link_zero[node] = nxt;
      node = nxt;
    end
    node_live[node] = 1'b1;
    node_hop[node]  = hop;
    node_port[node] = port & PORT_W'((1 << PORT_BITS) - 1);
    if (accepted_routes != COUNT_MAX) accepted_routes++;
    res.count = accepted_routes;
    return res;
  endfunction

  function automatic route_result_t lookup_route(logic [ADDR_W-1:0] addr);
    route_result_t    res;
    int unsigned      level;
    logic [IDX_W-1:0] node;
    res = '0;
    res.status = ST_DONE;
    res.count = accepted_routes;
    node = '0;
    level = 0;
    forever begin
      if (node_live[node]) begin
        res.found = 1'b1;
        res.hop   = node_hop[node];
        res.port  = node_port[node];
      end
      if (level >= ADDR_W) break;
      node = addr[5'(ADDR_W-1-level)] ? link_one[node] : link_zero[node];
      if (node == '0) break;
      level++;
    end
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t: result %0d: %s", $time, results, msg);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < NODE_COUNT; i++) clear_node(IDX_W'(i));
      free_node = 1;
      accepted_routes = '0;
      expected_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        results++;
        if (expected_q.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = expected_q.pop_front();
          if (found_i !== want.found)
            report_mismatch($sformatf("found %0b, expected %0b", found_i, want.found));
          if (hop_out_i !== want.hop)
            report_mismatch($sformatf("hop_out %h, expected %h", hop_out_i, want.hop));
          if (port_out_i !== want.port)
            report_mismatch($sformatf("port_out %h, expected %h", port_out_i, want.port));
          if (status_i !== want.status)
            report_mismatch($sformatf("status %0d, expected %s", status_i,
                                      want.status.name()));
          if (route_count_i !== want.count)
            report_mismatch($sformatf("route_count %0d, expected %0d", route_count_i,
                                      want.count));
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (kind_i == KIND_INSERT) begin
          want = insert_route(address_i, prefix_len_i, gateway_i, port_i);
        end else begin
          want = lookup_route(address_i);
        end
        if (want.status == ST_FULL) full_rejects++;
        if (want.status == ST_ZERO_LEN) zero_len++;
        if (want.found) hits++;
        expected_q.push_back(want);
      end
    end
    fails_o        <= fails;
    pending_o      <= expected_q.size();
    results_o      <= results;
    hits_o         <= hits;
    full_rejects_o <= full_rejects;
    zero_len_o     <= zero_len;
  end

endmodule

FILE: test/tb_binary_trie_route_lookup.sv
`timescale 1ns / 100ps

module tb_binary_trie_route_lookup;
  import btrl_pkg::*;

  localparam int unsigned CLK_HALF  = 6;
  localparam int unsigned NODES     = 4096;
  localparam int unsigned PORT_BITS = 8;
  localparam int unsigned MAX_CYCLES = 1_000_000;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    int unsigned       len;
  } prefix_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                kind = KIND_LOOKUP;
  logic [ADDR_W-1:0]   address = '0;
  logic [LEN_W-1:0]    prefix_len = '0;
  logic [HOP_W-1:0]    gateway = '0;
  logic [PORT_W-1:0]   port = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                found;
  logic [HOP_W-1:0]    hop_out;
  logic [PORT_W-1:0]   port_out;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  route_count;

  int unsigned fails, pending, results, hits, full_rejects, zero_len;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_off = 1'b0;
  int unsigned sent = 0;
  prefix_t     seen_q[$];
  logic [ADDR_W-1:0] hot_base [8];

  binary_trie_route_lookup #(
    .NODE_COUNT(NODES),
    .PORT_BITS (PORT_BITS)
  ) i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .kind_i       (kind),
    .address_i    (address),
    .prefix_len_i (prefix_len),
    .gateway_i    (gateway),
    .port_i       (port),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .found_o      (found),
    .hop_out_o    (hop_out),
    .port_out_o   (port_out),
    .status_o     (status),
    .route_count_o(route_count)
  );

  route_lookup_checker #(
    .NODE_COUNT(NODES),
    .PORT_BITS (PORT_BITS)
  ) i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .kind_i        (kind),
    .address_i     (address),
    .prefix_len_i  (prefix_len),
    .gateway_i     (gateway),
    .port_i        (port),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .found_i       (found),
    .hop_out_i     (hop_out),
    .port_out_i    (port_out),
    .status_i      (status),
    .route_count_i (route_count),
    .fails_o       (fails),
    .pending_o     (pending),
    .results_o     (results),
    .hits_o        (hits),
    .full_rejects_o(full_rejects),
    .zero_len_o    (zero_len)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  initial begin
    #(2 * CLK_HALF * MAX_CYCLES);
    $display("timeout, %0d transfers still expected", pending);
    $display("tb_binary_trie_route_lookup: errors");
    $finish;
  end

  always @(negedge clk) begin
    out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  task automatic send_item(logic k, logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len,
                           logic [HOP_W-1:0] hop, logic [PORT_W-1:0] prt);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    address    <= addr;
    prefix_len <= len;
    gateway    <= hop;
    port       <= prt;
    do begin
      @(posedge clk);
    end while (!in_ready);
    sent++;
  endtask

  task automatic send_lookup(logic [ADDR_W-1:0] addr);
    send_item(KIND_LOOKUP, addr, LEN_W'($urandom), $urandom, PORT_W'($urandom));
  endtask

  function automatic logic [ADDR_W-1:0] host_bits(int unsigned len);
    return (len >= ADDR_W) ? '0 : ({ADDR_W{1'b1}} >> len);
  endfunction

  task automatic remember(logic [ADDR_W-1:0] addr, int unsigned len);
    prefix_t p;
    if (len == 0) return;
    p.addr = addr;
    p.len  = (len > ADDR_W) ? ADDR_W : len;
    if (seen_q.size() >= 64) seen_q.delete($urandom_range(seen_q.size() - 1));
    seen_q.push_back(p);
  endtask

  task automatic directed_items();
    send_lookup(32'h0000_0000);
    send_item(KIND_INSERT, 32'hFFFF_FFFF, 6'd0, 32'h1234_5678, 8'h12);
    send_item(KIND_INSERT, 32'h0A00_0000, 6'd8, 32'hFFFF_FFFF, 8'hFF);
    send_item(KIND_INSERT, 32'h0A01_0000, 6'd16, 32'h0000_0000, 8'h00);
    send_item(KIND_INSERT, 32'h8000_0000, 6'd1, 32'hA5A5_A5A5, 8'h01);
    send_item(KIND_INSERT, 32'h0000_0000, 6'd1, 32'h5A5A_5A5A, 8'h80);
    send_item(KIND_INSERT, 32'hFFFF_FFFF, 6'd32, 32'hDEAD_BEEF, 8'h7F);
    send_item(KIND_INSERT, 32'h0000_0000, 6'd32, 32'h0000_0001, 8'hFE);
    send_item(KIND_INSERT, 32'hFFFF_FFFF, 6'd63, 32'hCAFE_F00D, 8'h55);
    send_item(KIND_INSERT, 32'h0A01_0203, 6'd33, 32'h1111_2222, 8'hAA);
    send_item(KIND_INSERT, 32'hAC10_0000, 6'd12, 32'h3333_4444, 8'h33);
    send_item(KIND_INSERT, 32'hFFFF_FFFE, 6'd31, 32'h7777_8888, 8'h44);
    send_lookup(32'h0A01_0203);
    send_lookup(32'h0A01_0204);
    send_lookup(32'h0A02_0000);
    send_lookup(32'hFFFF_FFFF);
    send_lookup(32'hFFFF_FFFE);
    send_lookup(32'h0000_0000);
    send_lookup(32'h7FFF_FFFF);
    send_lookup(32'hAC1F_0001);
    send_lookup(32'hAC20_0000);
    send_item(KIND_INSERT, 32'h0A00_0000, 6'd8, 32'h9999_0000, 8'h99);
    send_lookup(32'h0AFF_0000);
    send_lookup(32'h5555_5555);
    send_lookup(32'hAAAA_AAAA);
  endtask

  task automatic send_random();
    int unsigned       r, pick, len;
    logic [ADDR_W-1:0] addr;
    prefix_t           p;
    r = $urandom_range(99);
    pick = $urandom_range(9);
    if (r < 40) begin
      if (seen_q.size() > 0 && pick < 5) begin
        p = seen_q[$urandom_range(seen_q.size() - 1)];
        addr = (p.addr & ~host_bits(p.len)) | ($urandom & host_bits(p.len));
        len = (pick == 0) ? $urandom_range(p.len) : p.len + $urandom_range(4);
      end else if (pick < 8) begin
        addr = hot_base[3'($urandom_range(7))] ^ ($urandom >> $urandom_range(4, 32));
        len = $urandom_range(1, 32);
      end else begin
        addr = $urandom;
        len = $urandom_range(63);
      end
      send_item(KIND_INSERT, addr, LEN_W'(len), $urandom, PORT_W'($urandom));
      remember(addr, len);
    end else begin
      if (seen_q.size() > 0 && r < 85) begin
        p = seen_q[$urandom_range(seen_q.size() - 1)];
        addr = (r >= 80) ? p.addr : (p.addr & ~host_bits(p.len)) | ($urandom & host_bits(p.len));
      end else if (pick < 5) begin
        addr = hot_base[3'($urandom_range(7))] ^ ($urandom >> $urandom_range(8, 32));
      end else begin
        addr = $urandom;
      end
      send_lookup(addr);
    end
  endtask

  // long random routes of length 28 to 40 until the node pool runs out, then 30 more
  task automatic fill_pool();
    int unsigned       inserts, extra;
    logic [ADDR_W-1:0] addr;
    inserts = 0;
    extra = 0;
    while (extra < 30 && inserts < 400) begin
      addr = $urandom;
      send_item(KIND_INSERT, addr, LEN_W'($urandom_range(28, 40)), $urandom,
                PORT_W'($urandom));
      remember(addr, 28);
      inserts++;
      if (full_rejects != 0) extra++;
      if ($urandom_range(1)) send_lookup(addr ^ ($urandom >> $urandom_range(20, 32)));
    end
  endtask

  initial begin
    foreach (hot_base[i]) hot_base[i] = $urandom;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 0;
    stall_pct = 0;
    directed_items();
    repeat (260) send_random();

    send_idle_pct = 65;
    fill_pool();

    send_idle_pct = 0;
    stall_pct = 65;
    fork
      begin
        @(posedge clk);
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (40) send_random();
    join
    repeat (260) send_random();

    send_idle_pct = 33;
    stall_pct = 33;
    repeat (330) send_random();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("covered %0d transfers in, %0d results out, %0d lookups with a match",
             sent, results, hits);
    $display("inserts turned away: %0d of zero length, %0d on a full node pool",
             zero_len, full_rejects);
    if (fails == 0 && pending == 0) begin
      $display("tb_binary_trie_route_lookup: clean");
    end else begin
      $display("tb_binary_trie_route_lookup: errors");
    end
    $finish;
  end

endmodule
